### rtl/csp_pkg.sv
package csp_pkg;

  // default geometry of the weight store
  localparam int unsigned DefColumns = 64;
  localparam int unsigned DefCells   = 16;
  localparam int unsigned DefInter   = 32;

  // results per forward item never exceed this
  localparam int unsigned MaxRes = 16;

  // fixed-point constants
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [20:0] SumFloor = 21'd7;
  localparam int unsigned SumW     = 21;
  localparam int unsigned RecipW   = 30;

  // configuration register indexes
  localparam logic [1:0] CfgLearnRate = 2'd0;
  localparam logic [1:0] CfgCells     = 2'd1;
  localparam logic [1:0] CfgInter     = 2'd2;

  // result kinds
  localparam logic KindCell = 1'b0;
  localparam logic KindAck  = 1'b1;

  // sequencer states
  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_MOD  = 16'h0002,
    S_BASE = 16'h0004,
    S_RA   = 16'h0008,
    S_RD   = 16'h0010,
    S_X0   = 16'h0020,
    S_X1   = 16'h0040,
    S_X2   = 16'h0080,
    S_DIV  = 16'h0100,
    S_DIVW = 16'h0200,
    S_P0   = 16'h0400,
    S_P1   = 16'h0800,
    S_L0   = 16'h1000,
    S_L1   = 16'h2000,
    S_L2   = 16'h4000,
    S_ACK  = 16'h8000
  } state_e;

  // 2^(-j/16) in Q16, j = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### rtl/csp_if.sv
interface csp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [5:0] column;
  logic [4:0] inter_index;
  logic signed [4:0] target_cell;

  modport source (output valid, cmd, column, inter_index, target_cell, input ready);
  modport sink (input valid, cmd, column, inter_index, target_cell, output ready);
endinterface

interface csp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  cell_res;
  logic [15:0] probability;
  logic [3:0]  predicted_cell;
  logic        last;

  modport source (output valid, kind, cell_res, probability, predicted_cell, last,
                  input ready);
  modport sink (input valid, kind, cell_res, probability, predicted_cell, last,
                output ready);
endinterface

### rtl/csp_recip.sv
module csp_recip (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [csp_pkg::SumW-1:0]    den_i,
  output logic                        done_o,
  output logic [csp_pkg::RecipW-1:0]  quot_o
);
  import csp_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [5:0]        step_q;
  logic [SumW-1:0]   den_q;
  logic [SumW:0]     rem_q;
  logic [RecipW-1:0] quot_q;
  logic [SumW:0]     rem_sh;
  logic              fit;

  // one quotient bit of 2^32 / den per cycle
  assign rem_sh = {rem_q[SumW-1:0], (step_q == 6'd32)};
  assign fit    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 6'd32;
      end else if (busy_q) begin
        if (step_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 6'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fit ? rem_sh - {1'b0, den_q} : rem_sh;
      quot_q <= {quot_q[RecipW-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

### rtl/column_softmax_predictor.sv
// Column softmax predictor. A forward item (cmd 0) reads the Q3.12 weights of
// one column at one intermediate index, picks the argmax cell (first wins a
// tie), and returns one Q0.16 softmax probability per cell in use, the last
// result carrying the predicted cell; the probabilities are kept for learning.
// A learn item (cmd 1) moves the weights at the given index toward the one-hot
// target by learn_rate and returns a single acknowledge; target -1 skips the
// update. Everything runs through one shared multiplier and a bit-serial
// reciprocal, one item at a time: a forward item passes the setup states MOD
// and BASE, then the read states RA and RD for each cell in use, the exp states
// X0, X1 and X2 for each cell, the reciprocal, and the output states P0 and P1
// for each cell; a learn item passes MOD, BASE, then L0, L1 and L2 per cell and
// ACK; a stalled result receiver holds the sequencer in P1 or ACK.
// After reset the weight and probability stores are zeroed by a clearing pass
// over every weight address, during which no item is taken; configuration
// writes are accepted at any time but should be made while idle.
module column_softmax_predictor #(
  parameter int unsigned COLUMNS = csp_pkg::DefColumns,
  parameter int unsigned CELLS   = csp_pkg::DefCells,
  parameter int unsigned INTER   = csp_pkg::DefInter
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  csp_in_if.sink      in_i,
  csp_out_if.source   res_o
);
  import csp_pkg::*;

  localparam int unsigned CW     = CELLS * INTER;
  localparam int unsigned WDepth = COLUMNS * CW;
  localparam int unsigned PDepth = COLUMNS * CELLS;
  localparam int unsigned WAW    = $clog2(WDepth);
  localparam int unsigned PAW    = $clog2(PDepth);
  localparam int unsigned NMax   = (CELLS < MaxRes) ? CELLS : MaxRes;

  // configuration registers
  logic [15:0] learn_rate_q;
  logic [4:0]  cells_in_use_q;
  logic [5:0]  inter_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q   <= 16'd6554;
      cells_in_use_q <= 5'd16;
      inter_in_use_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLearnRate: learn_rate_q   <= cfg_data_i;
        CfgCells:     cells_in_use_q <= cfg_data_i[4:0];
        CfgInter:     inter_in_use_q <= cfg_data_i[5:0];
        default:      ;
      endcase
    end
  end

  state_e state_q;

  logic              clr_busy_q;
  logic [WAW-1:0]    clr_q;
  logic              cmd_q;
  logic [5:0]        col_q;
  logic [4:0]        ii_q;
  logic [4:0]        tgt_q;
  logic [4:0]        n_q;
  logic [4:0]        c_q;
  logic [WAW-1:0]    wptr_q;
  logic [PAW-1:0]    pptr_q;
  logic signed [15:0] w_q [MaxRes];
  logic [16:0]       e_q [MaxRes];
  logic signed [15:0] wmax_q;
  logic [3:0]        best_q;
  logic [SumW-1:0]   sum_q;
  logic [16:0]       base_q;
  logic [4:0]        k_q;
  logic [RecipW-1:0] recip_q;
  logic signed [50:0] mul_q;

  // output register
  logic        ovalid_q;
  logic        okind_q;
  logic [3:0]  ocell_q;
  logic [15:0] oprob_q;
  logic [3:0]  opred_q;
  logic        olast_q;

  // memories
  logic [15:0] wmem_q [WDepth];
  logic [15:0] pmem_q [PDepth];
  logic [15:0] wrd_q;
  logic [15:0] prd_q;

  // item decode at accept
  logic        in_acc;
  logic [8:0]  lim;
  logic [4:0]  ii_in;
  logic [4:0]  n_in;

  assign in_i.ready = (state_q == S_IDLE) && !clr_busy_q;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    lim = {3'b0, inter_in_use_q};
    if (lim == 9'd0) lim = 9'd1;
    if (32'(lim) > INTER) lim = 9'(INTER);
    ii_in = ({4'b0, in_i.inter_index} >= lim) ? 5'(lim - 9'd1) : in_i.inter_index;
    n_in = cells_in_use_q;
    if (n_in == 5'd0) n_in = 5'd1;
    if (32'(n_in) > NMax) n_in = 5'(NMax);
  end

  // shared multiplier operands
  logic signed [18:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_en;
  logic [16:0]        m_val;
  logic [16:0]        d_val;
  logic [16:0]        hot;
  logic signed [17:0] diff;

  assign m_val = 17'($signed({wmax_q[15], wmax_q}) - $signed({w_q[c_q[3:0]][15],
                 w_q[c_q[3:0]]}));
  assign d_val = pow2_neg({1'b0, mul_q[27:24]}) - pow2_neg(5'({1'b0, mul_q[27:24]}) + 5'd1);
  assign hot   = (!tgt_q[4] && tgt_q[3:0] == c_q[3:0]) ? 17'd65536 : 17'd0;
  assign diff  = $signed({1'b0, hot}) - $signed({2'b0, prd_q});

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      S_X0: begin
        mul_a = $signed({2'b0, m_val[15:0]});
        mul_b = $signed({15'b0, Log2eQ16});
      end
      S_X1: begin
        mul_a = $signed({2'b0, d_val});
        mul_b = $signed({20'b0, mul_q[23:12]});
      end
      S_P0: begin
        mul_a = $signed({2'b0, e_q[c_q[3:0]]});
        mul_b = $signed({2'b0, recip_q});
      end
      S_L1: begin
        mul_a = {diff[17], diff};
        mul_b = $signed({16'b0, learn_rate_q});
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) mul_q <= 51'(mul_a) * 51'(mul_b);
  end

  // exp finish, probability and weight update
  logic [16:0]        e_raw;
  logic [16:0]        e_val;
  logic [15:0]        p_val;
  logic signed [50:0] lsum;
  logic signed [17:0] wsum;
  logic [15:0]        wnew;
  logic               last_c;
  logic               out_free;

  assign e_raw  = base_q - {5'b0, mul_q[23:12]};
  assign e_val  = (k_q >= 5'd17) ? 17'd0 : (e_raw >> k_q);
  assign p_val  = (mul_q[50:32] != '0) ? 16'hFFFF : mul_q[31:16];
  assign lsum   = mul_q + 51'sd524288;
  assign wsum   = $signed({{2{wrd_q[15]}}, wrd_q}) + $signed(lsum[37:20]);
  assign wnew   = (wsum > 18'sd32767) ? 16'h7FFF :
                  (wsum < -18'sd32768) ? 16'h8000 : wsum[15:0];
  assign last_c = (c_q + 5'd1) == n_q;
  assign out_free = !ovalid_q || res_o.ready;

  // reciprocal unit
  logic                div_start;
  logic [SumW-1:0]     div_den;
  logic                div_done;
  logic [RecipW-1:0]   div_quot;

  assign div_start = (state_q == S_DIV);
  assign div_den   = (sum_q < SumFloor) ? SumFloor : sum_q;

  csp_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // memory write controls
  logic           w_we;
  logic [WAW-1:0] w_wa;
  logic [15:0]    w_wd;
  logic           p_we;
  logic [PAW-1:0] p_wa;
  logic [15:0]    p_wd;
  logic           p_load;

  assign p_load = (state_q == S_P1) && out_free;
  assign w_we   = clr_busy_q || (state_q == S_L2);
  assign w_wa   = clr_busy_q ? clr_q : wptr_q;
  assign w_wd   = clr_busy_q ? 16'd0 : wnew;
  assign p_we   = (clr_busy_q && (32'(clr_q) < PDepth)) || p_load;
  assign p_wa   = clr_busy_q ? PAW'(clr_q) : pptr_q;
  assign p_wd   = clr_busy_q ? 16'd0 : p_val;

  always_ff @(posedge clk_i) begin
    if (w_we) wmem_q[w_wa] <= w_wd;
    wrd_q <= wmem_q[wptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pmem_q[p_wa] <= p_wd;
    prd_q <= pmem_q[pptr_q];
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      if (clr_q == WAW'(WDepth - 1)) clr_busy_q <= 1'b0;
      clr_q <= clr_q + 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_acc) state_q <= S_MOD;
        S_MOD:  if (32'(col_q) < COLUMNS) state_q <= S_BASE;
        S_BASE: state_q <= cmd_q ? ((tgt_q == 5'b11111) ? S_ACK : S_L0) : S_RA;
        S_RA:   state_q <= S_RD;
        S_RD:   state_q <= last_c ? S_X0 : S_RA;
        S_X0:   state_q <= S_X1;
        S_X1:   state_q <= S_X2;
        S_X2:   state_q <= last_c ? S_DIV : S_X0;
        S_DIV:  state_q <= S_DIVW;
        S_DIVW: if (div_done) state_q <= S_P0;
        S_P0:   state_q <= S_P1;
        S_P1:   if (out_free) state_q <= last_c ? S_IDLE : S_P0;
        S_L0:   state_q <= S_L1;
        S_L1:   state_q <= S_L2;
        S_L2:   state_q <= last_c ? S_ACK : S_L0;
        S_ACK:  if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q <= in_i.cmd;
        col_q <= in_i.column;
        ii_q  <= ii_in;
        tgt_q <= in_i.target_cell;
        n_q   <= n_in;
      end
      S_MOD: begin
        if (32'(col_q) >= COLUMNS) col_q <= col_q - 6'(COLUMNS);
        c_q    <= '0;
        sum_q  <= '0;
      end
      S_BASE: begin
        wptr_q <= WAW'(32'(col_q) * CW) + WAW'(ii_q);
        pptr_q <= PAW'(32'(col_q) * CELLS);
      end
      S_RD: begin
        w_q[c_q[3:0]] <= $signed(wrd_q);
        if (c_q == 5'd0 || $signed(wrd_q) > wmax_q) begin
          wmax_q <= $signed(wrd_q);
          best_q <= c_q[3:0];
        end
        wptr_q <= wptr_q + WAW'(INTER);
        c_q    <= last_c ? 5'd0 : c_q + 5'd1;
      end
      S_X1: begin
        base_q <= pow2_neg({1'b0, mul_q[27:24]});
        k_q    <= mul_q[32:28];
      end
      S_X2: begin
        e_q[c_q[3:0]] <= e_val;
        sum_q <= sum_q + SumW'(e_val);
        c_q   <= last_c ? 5'd0 : c_q + 5'd1;
      end
      S_DIVW: if (div_done) recip_q <= div_quot;
      S_P1: begin
        if (out_free) begin
          pptr_q <= pptr_q + 1'b1;
          c_q    <= c_q + 5'd1;
        end
      end
      S_L2: begin
        wptr_q <= wptr_q + WAW'(INTER);
        pptr_q <= pptr_q + 1'b1;
        c_q    <= c_q + 5'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if ((state_q == S_P1 || state_q == S_ACK) && out_free) begin
      ovalid_q <= 1'b1;
    end else if (res_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_load) begin
      okind_q <= KindCell;
      ocell_q <= c_q[3:0];
      oprob_q <= p_val;
      opred_q <= last_c ? best_q : 4'd0;
      olast_q <= last_c;
    end else if (state_q == S_ACK && out_free) begin
      okind_q <= KindAck;
      ocell_q <= 4'd0;
      oprob_q <= 16'd0;
      opred_q <= 4'd0;
      olast_q <= 1'b1;
    end
  end

  assign res_o.valid          = ovalid_q;
  assign res_o.kind           = okind_q;
  assign res_o.cell_res       = ocell_q;
  assign res_o.probability    = oprob_q;
  assign res_o.predicted_cell = opred_q;
  assign res_o.last           = olast_q;

`ifndef NO_ASSERTIONS
  // no item is taken while the stores are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_i.ready) else $error("item taken during clearing pass");

  // an accepted item always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_MOD) else $error("accepted item did not start");

  // the reciprocal never sees a sum below the floor
  a_div_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_den >= SumFloor) else $error("reciprocal below floor");
`endif

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csp_pkg::*;

  localparam int unsigned Columns = 64;
  localparam int unsigned Cells   = 16;
  localparam int unsigned Inter   = 32;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 300;
  localparam logic CmdForward = 1'b0;
  localparam logic CmdLearn   = 1'b1;
  localparam logic signed [4:0] NoTarget = -5'sd1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  cell_res;
    logic [15:0] probability;
    logic [3:0]  predicted_cell;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgLearnRate;
  logic [15:0] cfg_data_i = '0;

  csp_in_if  in_bus();
  csp_out_if res_bus();

  column_softmax_predictor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .res_o      (res_bus)
  );

  // shadow state of the block
  logic signed [15:0] weight_mem [Columns*Cells*Inter];
  logic [15:0]        prob_mem [Columns*Cells];
  logic [15:0]        beta;
  logic [4:0]         cells_reg;
  logic [5:0]         inter_reg;
  int unsigned        pow2_tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                        48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                        35734, 34219, 32768};

  result_t     pending_results [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_left = 0;

  always #5 clk_i = ~clk_i;

  // exp(-m/4096) in q16 via a power-of-two table
  function automatic int unsigned exp_q16(int unsigned m);
    longint unsigned t;
    int unsigned k, f, j, r, v;
    t = longint'(m) * 94548;
    k = int'(t >> 28);
    f = int'((t >> 12) & 64'hFFFF);
    j = f >> 12;
    r = f & 12'hFFF;
    if (k >= 17) return 0;
    v = pow2_tab[j] - (((pow2_tab[j] - pow2_tab[j+1]) * r) >> 12);
    return v >> k;
  endfunction

  // update shadow state and queue the results of one accepted item
  task automatic predict_item(logic cmd, logic [5:0] col, logic [4:0] ii_raw,
                              logic signed [4:0] tgt);
    int unsigned n, lim, ii, best, wbase, pbase;
    int          w [16];
    int unsigned e [16];
    longint unsigned sum, recip, p;
    longint      diff, delta, nw;
    result_t     r;
    n = (cells_reg < 1) ? 1 : (cells_reg > Cells) ? Cells : cells_reg;
    lim = (inter_reg < 1) ? 1 : (inter_reg > Inter) ? Inter : inter_reg;
    ii = (ii_raw >= lim) ? lim - 1 : ii_raw;
    wbase = col * Cells * Inter;
    pbase = col * Cells;
    if (cmd == CmdLearn) begin
      if (tgt != NoTarget) begin
        for (int c = 0; c < n; c++) begin
          diff = ((tgt >= 0 && c == tgt) ? 65536 : 0) - longint'(prob_mem[pbase+c]);
          delta = (longint'(beta) * diff + (64'sd1 <<< 19)) >>> 20;
          nw = longint'(weight_mem[wbase+c*Inter+ii]) + delta;
          if (nw > 32767) nw = 32767;
          if (nw < -32768) nw = -32768;
          weight_mem[wbase+c*Inter+ii] = nw[15:0];
        end
      end
      r = '{kind: KindAck, cell_res: 4'd0, probability: 16'd0, predicted_cell: 4'd0,
            last: 1'b1};
      pending_results.push_back(r);
    end else begin
      best = 0;
      for (int c = 0; c < n; c++) begin
        w[c] = weight_mem[wbase+c*Inter+ii];
        if (c == 0 || w[c] > w[best]) best = c;
      end
      sum = 0;
      for (int c = 0; c < n; c++) begin
        e[c] = exp_q16(w[best] - w[c]);
        sum += e[c];
      end
      if (sum < 7) sum = 7;
      recip = (64'd1 << 32) / sum;
      for (int c = 0; c < n; c++) begin
        p = (longint'(e[c]) * recip) >> 16;
        if (p > 65535) p = 65535;
        prob_mem[pbase+c] = p[15:0];
        r.kind = KindCell;
        r.cell_res = c[3:0];
        r.probability = p[15:0];
        r.predicted_cell = (c == n - 1) ? best[3:0] : 4'd0;
        r.last = (c == n - 1);
        pending_results.push_back(r);
      end
    end
  endtask

  // offer one item, with random gaps ahead of it
  task automatic send_item(logic cmd, logic [5:0] col, logic [4:0] ii,
                           logic signed [4:0] tgt);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.cmd <= cmd;
    in_bus.column <= col;
    in_bus.inter_index <= ii;
    in_bus.target_cell <= tgt;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_item(cmd, col, ii, tgt);
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_cfg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgLearnRate: beta = value;
      CfgCells:     cells_reg = value[4:0];
      CfgInter:     inter_reg = value[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] lr, logic [15:0] cells, logic [15:0] inter);
    drain_block();
    write_cfg(CfgLearnRate, lr);
    write_cfg(CfgCells, cells);
    write_cfg(CfgInter, inter);
  endtask

  // forward then learn on the same slot
  task automatic predict_and_learn(logic [5:0] col, logic [4:0] ii, logic signed [4:0] tgt);
    send_item(CmdForward, col, ii, 5'($urandom_range(31)));
    send_item(CmdLearn, col, ii, tgt);
  endtask

  task automatic test_directed();
    // learn into a fresh column sees zero probabilities
    send_item(CmdLearn, 6'd5, 5'd3, 5'sd2);
    send_item(CmdForward, 6'd5, 5'd3, 5'sd0);
    // all-zero weights tie, first cell wins
    send_item(CmdForward, 6'd0, 5'd0, -5'sd16);
    send_item(CmdForward, 6'd63, 5'd31, 5'sd15);
    predict_and_learn(6'd63, 5'd31, 5'sd15);
    predict_and_learn(6'd63, 5'd31, 5'sd0);
    predict_and_learn(6'd0, 5'd0, NoTarget);
    predict_and_learn(6'd0, 5'd0, -5'sd16);
    send_item(CmdForward, 6'd0, 5'd0, 5'sd0);
    // saturate the weights with the largest rate
    set_config(16'hFFFF, 16'd16, 16'd32);
    for (int i = 0; i < 5; i++) predict_and_learn(6'd7, 5'd9, 5'sd4);
    send_item(CmdLearn, 6'd7, 5'd9, 5'sd4);
    send_item(CmdLearn, 6'd7, 5'd9, 5'sd4);
    send_item(CmdForward, 6'd7, 5'd9, 5'sd0);
    // zero rate, single cell, single index, clamped counts
    set_config(16'd0, 16'd1, 16'd1);
    predict_and_learn(6'd7, 5'd31, 5'sd0);
    set_config(16'hFFE0, 16'h0000, 16'h0000);
    predict_and_learn(6'd7, 5'd20, 5'sd1);
    set_config(16'd6554, 16'h001F, 16'h003F);
    predict_and_learn(6'd7, 5'd9, 5'sd15);
  endtask

  task automatic test_random(int unsigned sidle, int unsigned ridle, int unsigned pairs);
    logic [5:0] col;
    logic [4:0] ii;
    int unsigned n;
    set_config(16'($urandom), 16'($urandom_range(16, 1)), 16'($urandom_range(32, 1)));
    send_idle = sidle;
    recv_idle = ridle;
    n = (cells_reg < 1) ? 1 : (cells_reg > Cells) ? Cells : cells_reg;
    for (int i = 0; i < pairs; i++) begin
      col = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(3));
      ii = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
      case ($urandom_range(9))
        0: send_item(CmdLearn, col, ii, 5'($urandom));
        1: send_item(CmdForward, col, ii, 5'($urandom));
        2: predict_and_learn(col, ii, 5'($urandom));
        default: predict_and_learn(col, ii, 5'($urandom_range(n - 1)));
      endcase
    end
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_backpressure();
    set_config(16'd30000, 16'd16, 16'd32);
    send_idle = 0;
    recv_idle = 0;
    hold_left = 3000;
    for (int i = 0; i < 4; i++) predict_and_learn(6'd2, 5'($urandom), 5'($urandom_range(15)));
  endtask

  // receiver side, ready changes on the falling edge
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d cell=%0d", res_bus.kind, res_bus.cell_res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_bus.kind !== want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, res_bus.kind);
          fail_count++;
        end
        if (res_bus.cell_res !== want.cell_res) begin
          $error("cell_res: expected %0d actual %0d", want.cell_res, res_bus.cell_res);
          fail_count++;
        end
        if (res_bus.probability !== want.probability) begin
          $error("probability: expected %0d actual %0d", want.probability,
                 res_bus.probability);
          fail_count++;
        end
        if (res_bus.predicted_cell !== want.predicted_cell) begin
          $error("predicted_cell: expected %0d actual %0d", want.predicted_cell,
                 res_bus.predicted_cell);
          fail_count++;
        end
        if (res_bus.last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, res_bus.last);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.cmd = CmdForward;
    in_bus.column = '0;
    in_bus.inter_index = '0;
    in_bus.target_cell = '0;
    res_bus.ready = 1'b0;
    foreach (weight_mem[i]) weight_mem[i] = '0;
    foreach (prob_mem[i]) prob_mem[i] = '0;
    beta = 16'd6554;
    cells_reg = 5'd16;
    inter_reg = 6'd32;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(13, 72, 35);
    test_random(72, 13, 35);
    test_random(0, 0, 35);
    test_backpressure();
    drain_block();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/csp_pkg.sv
rtl/csp_if.sv
rtl/csp_recip.sv
rtl/column_softmax_predictor.sv
test/tb.sv
